// ===== hw/rtl/ppm_p6_pkg.sv =====
// ----------------------------------------------------------------------------
// ppm_p6_pkg
// Shared widths, codes, result types and helpers for the P6 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ppm_p6_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned DIM_W       = 16;
  localparam int unsigned NUM_W       = 32;
  localparam int unsigned NUM_EXT_W   = NUM_W + 4;
  localparam int unsigned CNT_W       = 37;
  localparam int unsigned MAXIN_W     = 36;
  localparam int unsigned MAXPIX_W    = 32;
  localparam int unsigned MAXDEC_W    = 35;
  localparam int unsigned RAS_W       = 34;
  localparam int unsigned TOKLEN_W    = 3;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned ERR_W       = 4;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 36;

  localparam logic [MAXIN_W-1:0]  RST_MAX_INPUT_BYTES   = 36'd268435456;
  localparam logic [DIM_W-1:0]    RST_MAX_WIDTH         = 16'd16384;
  localparam logic [DIM_W-1:0]    RST_MAX_HEIGHT        = 16'd16384;
  localparam logic [MAXPIX_W-1:0] RST_MAX_PIXELS        = 32'd67108864;
  localparam logic [MAXDEC_W-1:0] RST_MAX_DECODED_BYTES = 35'd268435456;

  localparam logic [BYTE_W-1:0] CH_HASH      = 8'h23;
  localparam logic [BYTE_W-1:0] CH_P         = 8'h50;
  localparam logic [BYTE_W-1:0] CH_SIX       = 8'h36;
  localparam logic [BYTE_W-1:0] CH_ZERO      = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE      = 8'h39;
  localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [NUM_W-1:0]  MAXVAL_REQ   = 32'd255;
  localparam logic [TOKLEN_W-1:0] MAGIC_LEN  = 3'd2;

  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_WIDTH  = 3'd1,
    PH_HEIGHT = 3'd2,
    PH_MAXVAL = 3'd3,
    PH_BODY   = 3'd4
  } phase_t;

  typedef enum logic {
    RAS_RUN  = 1'b0,
    RAS_DONE = 1'b1
  } ras_state_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_TOO_LONG      = 4'd0,
    ERR_TOKEN_MISSING = 4'd1,
    ERR_MAGIC         = 4'd2,
    ERR_WIDTH         = 4'd3,
    ERR_HEIGHT        = 4'd4,
    ERR_MAXVAL_SYNTAX = 4'd5,
    ERR_MAXVAL_VALUE  = 4'd6,
    ERR_SEPARATOR     = 4'd7,
    ERR_DIMS          = 4'd8,
    ERR_SIZE          = 4'd9,
    ERR_RASTER        = 4'd10
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_INPUT_BYTES   = 3'd0,
    CFG_MAX_WIDTH         = 3'd1,
    CFG_MAX_HEIGHT        = 3'd2,
    CFG_MAX_PIXELS        = 3'd3,
    CFG_MAX_DECODED_BYTES = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    err_t              err;
    logic              last;
  } res_t;

  typedef struct packed {
    logic             dims_bad;
    logic             size_bad;
    logic [RAS_W-1:0] raster_len;
  } dim_t;

  typedef struct packed {
    logic             go;
    logic             cr;
    logic [RAS_W-1:0] len;
  } ras_start_t;

  function automatic logic is_space(logic [BYTE_W-1:0] c);
    return c inside {8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0C, 8'h0B};
  endfunction

  function automatic res_t res_none();
    res_t r;
    r = '0;
    return r;
  endfunction

  function automatic res_t res_err(err_t code);
    res_t r;
    r       = '0;
    r.valid = 1'b1;
    r.kind  = KIND_ERROR;
    r.err   = code;
    return r;
  endfunction

  function automatic res_t res_header(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    res_t r;
    r        = '0;
    r.valid  = 1'b1;
    r.kind   = KIND_HEADER;
    r.width  = w;
    r.height = h;
    return r;
  endfunction

  function automatic res_t res_pixel(logic [BYTE_W-1:0] rd, logic [BYTE_W-1:0] gr,
                                     logic [BYTE_W-1:0] bl, logic lst);
    res_t r;
    r       = '0;
    r.valid = 1'b1;
    r.kind  = KIND_PIXEL;
    r.red   = rd;
    r.green = gr;
    r.blue  = bl;
    r.alpha = ALPHA_OPAQUE;
    r.last  = lst;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ppm_p6_dim.sv =====
// ----------------------------------------------------------------------------
// ppm_p6_dim
// Pixel count and raster length from the parsed dimensions, and limit checks.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_p6_dim import ppm_p6_pkg::*; (
  input  logic                clk,
  input  logic [NUM_W-1:0]    img_width,
  input  logic [NUM_W-1:0]    img_height,
  input  logic [DIM_W-1:0]    cap_width,
  input  logic [DIM_W-1:0]    cap_height,
  input  logic [MAXPIX_W-1:0] cap_pixels,
  input  logic [MAXDEC_W-1:0] cap_dec_bytes,
  output dim_t                dim
);

  logic [2*DIM_W-1:0] pixels_r;
  logic [RAS_W-1:0]   raster_len_r;

  always_ff @(posedge clk) begin
    pixels_r     <= {{DIM_W{1'b0}}, img_width[DIM_W-1:0]} *
                    {{DIM_W{1'b0}}, img_height[DIM_W-1:0]};
    raster_len_r <= {1'b0, pixels_r, 1'b0} + {2'b00, pixels_r};
  end

  always_comb begin
    dim.dims_bad   = (img_width == '0) || (img_height == '0) ||
                     (img_width  > {{(NUM_W-DIM_W){1'b0}}, cap_width}) ||
                     (img_height > {{(NUM_W-DIM_W){1'b0}}, cap_height});
    dim.size_bad   = (pixels_r > cap_pixels) ||
                     ({1'b0, pixels_r} > cap_dec_bytes[MAXDEC_W-1:2]);
    dim.raster_len = raster_len_r;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ppm_p6_hdr.sv =====
// ----------------------------------------------------------------------------
// ppm_p6_hdr
// Header tokenizer: magic, width, height and maximum value, then separator.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_p6_hdr import ppm_p6_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              clear,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              eof,
  input  dim_t              dim,
  output res_t              res,
  output ras_start_t        start,
  output logic              in_body,
  output logic [NUM_W-1:0]  img_width,
  output logic [NUM_W-1:0]  img_height
);

  typedef struct packed {
    logic fail;
    err_t code;
  } jdg_t;

  phase_t              phase_r,   phase_nxt;
  logic                comment_r, comment_nxt;
  logic [TOKLEN_W-1:0] len_r,     len_nxt;
  logic                match_r,   match_nxt;
  logic [NUM_W-1:0]    accum_r,   accum_nxt;
  logic                ovf_r,     ovf_nxt;
  logic                bad_r,     bad_nxt;
  logic [NUM_W-1:0]    width_r,   width_nxt;
  logic [NUM_W-1:0]    height_r,  height_nxt;

  logic                sp;
  logic                hash;
  logic                digit;
  logic [NUM_EXT_W-1:0] mul10;
  logic [TOKLEN_W-1:0] ab_len;
  logic                ab_match;
  logic [NUM_W-1:0]    ab_accum;
  logic                ab_ovf;
  logic                ab_bad;
  jdg_t                cur_j;
  jdg_t                nxt_j;

  function automatic jdg_t judge(phase_t ph, logic [TOKLEN_W-1:0] len, logic mt,
                                 logic [NUM_W-1:0] acc, logic ov, logic bd);
    jdg_t j;
    j.fail = 1'b0;
    j.code = ERR_MAGIC;
    case (ph)
      PH_MAGIC: begin
        j.fail = !(mt && (len == MAGIC_LEN));
        j.code = ERR_MAGIC;
      end
      PH_WIDTH: begin
        j.fail = ov || bd;
        j.code = ERR_WIDTH;
      end
      PH_HEIGHT: begin
        j.fail = ov || bd;
        j.code = ERR_HEIGHT;
      end
      default: begin
        if (ov || bd) begin
          j.fail = 1'b1;
          j.code = ERR_MAXVAL_SYNTAX;
        end else begin
          j.fail = (acc != MAXVAL_REQ);
          j.code = ERR_MAXVAL_VALUE;
        end
      end
    endcase
    return j;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MAGIC;
      comment_r <= 1'b0;
      len_r     <= '0;
      match_r   <= 1'b1;
      accum_r   <= '0;
      ovf_r     <= 1'b0;
      bad_r     <= 1'b0;
      width_r   <= '0;
      height_r  <= '0;
    end else begin
      phase_r   <= phase_nxt;
      comment_r <= comment_nxt;
      len_r     <= len_nxt;
      match_r   <= match_nxt;
      accum_r   <= accum_nxt;
      ovf_r     <= ovf_nxt;
      bad_r     <= bad_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
    end
  end

  always_comb begin
    sp    = is_space(byte_in);
    hash  = (byte_in == CH_HASH);
    digit = byte_in inside {[CH_ZERO:CH_NINE]};
    mul10 = {1'b0, accum_r, 3'b000} + {3'b000, accum_r, 1'b0} +
            {{(NUM_EXT_W-4){1'b0}}, byte_in[3:0]};

    ab_len   = (len_r != '1) ? len_r + 1'b1 : len_r;
    ab_match = match_r;
    ab_accum = accum_r;
    ab_ovf   = ovf_r;
    ab_bad   = bad_r;
    if (phase_r == PH_MAGIC) begin
      ab_match = match_r && (((len_r == '0) && (byte_in == CH_P)) ||
                             ((len_r == 3'd1) && (byte_in == CH_SIX)));
    end else if (digit) begin
      ab_accum = mul10[NUM_W-1:0];
      ab_ovf   = ovf_r || (mul10[NUM_EXT_W-1:NUM_W] != '0);
    end else begin
      ab_bad = 1'b1;
    end

    cur_j = judge(phase_r, len_r, match_r, accum_r, ovf_r, bad_r);

    phase_nxt   = phase_r;
    comment_nxt = comment_r;
    len_nxt     = len_r;
    match_nxt   = match_r;
    accum_nxt   = accum_r;
    ovf_nxt     = ovf_r;
    bad_nxt     = bad_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    res         = res_none();
    start       = '0;

    if (step && (phase_r != PH_BODY)) begin
      if ((len_r != '0) && (sp || hash)) begin
        if (cur_j.fail) begin
          res = res_err(cur_j.code);
        end else if (phase_r == PH_MAXVAL) begin
          if (hash) begin
            res = res_err(ERR_SEPARATOR);
          end else if (dim.dims_bad) begin
            res = res_err(ERR_DIMS);
          end else if (dim.size_bad) begin
            res = res_err(ERR_SIZE);
          end else begin
            phase_nxt = PH_BODY;
            start.go  = 1'b1;
            start.cr  = (byte_in == CH_CR);
            start.len = dim.raster_len;
            res = eof ? res_err(ERR_RASTER)
                      : res_header(width_r[DIM_W-1:0], height_r[DIM_W-1:0]);
          end
        end else begin
          case (phase_r)
            PH_MAGIC:  phase_nxt = PH_WIDTH;
            PH_WIDTH: begin
              phase_nxt = PH_HEIGHT;
              width_nxt = accum_r;
            end
            PH_HEIGHT: begin
              phase_nxt  = PH_MAXVAL;
              height_nxt = accum_r;
            end
            default:   phase_nxt = phase_r;
          endcase
          len_nxt     = '0;
          match_nxt   = 1'b1;
          accum_nxt   = '0;
          ovf_nxt     = 1'b0;
          bad_nxt     = 1'b0;
          comment_nxt = hash;
          if (eof) begin
            res = res_err(ERR_TOKEN_MISSING);
          end
        end
      end else begin
        if ((len_r != '0) || (!comment_r && !hash && !sp)) begin
          len_nxt   = ab_len;
          match_nxt = ab_match;
          accum_nxt = ab_accum;
          ovf_nxt   = ab_ovf;
          bad_nxt   = ab_bad;
        end else if (comment_r) begin
          if ((byte_in == CH_LF) || (byte_in == CH_CR)) begin
            comment_nxt = 1'b0;
          end
        end else if (hash) begin
          comment_nxt = 1'b1;
        end
        if (eof) begin
          if (len_nxt == '0) begin
            res = res_err(ERR_TOKEN_MISSING);
          end else if (nxt_j.fail) begin
            res = res_err(nxt_j.code);
          end else begin
            res = res_err((phase_r == PH_MAXVAL) ? ERR_SEPARATOR : ERR_TOKEN_MISSING);
          end
        end
      end
    end

    if (clear) begin
      phase_nxt   = PH_MAGIC;
      comment_nxt = 1'b0;
      len_nxt     = '0;
      match_nxt   = 1'b1;
      accum_nxt   = '0;
      ovf_nxt     = 1'b0;
      bad_nxt     = 1'b0;
      width_nxt   = '0;
      height_nxt  = '0;
    end
  end

  assign nxt_j      = judge(phase_r, ab_len, ab_match, ab_accum, ab_ovf, ab_bad);
  assign in_body    = (phase_r == PH_BODY);
  assign img_width  = width_r;
  assign img_height = height_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ppm_p6_ras.sv =====
// ----------------------------------------------------------------------------
// ppm_p6_ras
// Raster unpacker: gathers three bytes into one RGBA pixel, counts length.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_p6_ras import ppm_p6_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              clear,
  input  ras_start_t        start,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              eof,
  output res_t              res
);

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;

  ras_state_t        state_r, state_nxt;
  logic              cr_r,    cr_nxt;
  logic [RAS_W-1:0]  rem_r,   rem_nxt;
  logic [1:0]        chan_r,  chan_nxt;
  logic [BYTE_W-1:0] red_r,   red_nxt;
  logic [BYTE_W-1:0] green_r, green_nxt;
  logic [RAS_W-1:0]  rem_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RAS_RUN;
      cr_r    <= 1'b0;
      rem_r   <= '0;
      chan_r  <= CHAN_RED;
      red_r   <= '0;
      green_r <= '0;
    end else begin
      state_r <= state_nxt;
      cr_r    <= cr_nxt;
      rem_r   <= rem_nxt;
      chan_r  <= chan_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cr_nxt    = cr_r;
    rem_nxt   = rem_r;
    chan_nxt  = chan_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    res       = res_none();
    rem_dec   = (rem_r != '0) ? rem_r - 1'b1 : rem_r;

    if (start.go) begin
      state_nxt = RAS_RUN;
      cr_nxt    = start.cr;
      rem_nxt   = start.len;
      chan_nxt  = CHAN_RED;
    end else if (step) begin
      if (state_r == RAS_DONE) begin
        res = res_err(ERR_RASTER);
      end else if (cr_r && (byte_in == CH_LF)) begin
        cr_nxt = 1'b0;
        if (eof) begin
          res = res_err(ERR_RASTER);
        end
      end else begin
        cr_nxt  = 1'b0;
        rem_nxt = rem_dec;
        case (chan_r)
          CHAN_RED: begin
            red_nxt  = byte_in;
            chan_nxt = CHAN_GREEN;
            if (eof) res = res_err(ERR_RASTER);
          end
          CHAN_GREEN: begin
            green_nxt = byte_in;
            chan_nxt  = CHAN_BLUE;
            if (eof) res = res_err(ERR_RASTER);
          end
          default: begin
            chan_nxt = CHAN_RED;
            if (rem_dec == '0) begin
              state_nxt = RAS_DONE;
              res       = res_pixel(red_r, green_r, byte_in, eof);
            end else if (eof) begin
              res = res_err(ERR_RASTER);
            end else begin
              res = res_pixel(red_r, green_r, byte_in, 1'b0);
            end
          end
        endcase
      end
    end

    if (clear) begin
      state_nxt = RAS_RUN;
      cr_nxt    = 1'b0;
      rem_nxt   = '0;
      chan_nxt  = CHAN_RED;
      red_nxt   = '0;
      green_nxt = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ppm_p6_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// ppm_p6_stream_decoder_top
// Binary PPM (P6) stream decoder: header parse, limit checks, RGBA pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one file byte per item in in_tdata, in_tlast on the final byte.
//   out_* : results; out_tuser is the kind (header, pixel, error), out_tlast
//           marks the final pixel of an image whose last byte ended the file.
//   cfg_* : limit registers, written while no item is in flight.
// Each accepted byte yields zero or one result, registered in the cycle
// after acceptance. One byte is taken every cycle unless stalled; the output
// register alone separates the channels, so in_tready falls only while a
// result is held and out_tready is low. A stalled receiver therefore stalls
// the input after one result. After an error nothing more is emitted until
// in_tlast; the last byte of a file always returns the parser to its start
// state, limits kept. Reset clears the parser, the output register and the
// limits to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_p6_stream_decoder_top import ppm_p6_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // data_byte
  input  logic                   in_tlast,   // end_of_file
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // image_width, image_height, red, green, blue, alpha, error_code, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [KIND_W-1:0]      out_tuser,  // kind
  output logic                   out_tlast,  // final_res
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [MAXIN_W-1:0]  max_in_r;
  logic [DIM_W-1:0]    max_w_r;
  logic [DIM_W-1:0]    max_h_r;
  logic [MAXPIX_W-1:0] max_pix_r;
  logic [MAXDEC_W-1:0] max_dec_r;

  logic [CNT_W-1:0]    cnt_r,    cnt_nxt;
  logic                failed_r, failed_nxt;
  logic                ovalid_r, ovalid_nxt;
  res_t                ores_r;

  logic                acc;
  logic                live;
  logic                over;
  logic                step;
  logic                clear;
  logic                in_body;
  res_t                hdr_res;
  res_t                ras_res;
  res_t                res;
  ras_start_t          start;
  dim_t                dim;
  logic [NUM_W-1:0]    img_width;
  logic [NUM_W-1:0]    img_height;

  ppm_p6_dim u_dim (
    .clk           (clk),
    .img_width     (img_width),
    .img_height    (img_height),
    .cap_width     (max_w_r),
    .cap_height    (max_h_r),
    .cap_pixels    (max_pix_r),
    .cap_dec_bytes (max_dec_r),
    .dim           (dim)
  );

  ppm_p6_hdr u_hdr (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .clear      (clear),
    .byte_in    (in_tdata),
    .eof        (in_tlast),
    .dim        (dim),
    .res        (hdr_res),
    .start      (start),
    .in_body    (in_body),
    .img_width  (img_width),
    .img_height (img_height)
  );

  ppm_p6_ras u_ras (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step && in_body),
    .clear   (clear),
    .start   (start),
    .byte_in (in_tdata),
    .eof     (in_tlast),
    .res     (ras_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_in_r  <= RST_MAX_INPUT_BYTES;
      max_w_r   <= RST_MAX_WIDTH;
      max_h_r   <= RST_MAX_HEIGHT;
      max_pix_r <= RST_MAX_PIXELS;
      max_dec_r <= RST_MAX_DECODED_BYTES;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_INPUT_BYTES:   max_in_r  <= cfg_data[MAXIN_W-1:0];
        CFG_MAX_WIDTH:         max_w_r   <= cfg_data[DIM_W-1:0];
        CFG_MAX_HEIGHT:        max_h_r   <= cfg_data[DIM_W-1:0];
        CFG_MAX_PIXELS:        max_pix_r <= cfg_data[MAXPIX_W-1:0];
        CFG_MAX_DECODED_BYTES: max_dec_r <= cfg_data[MAXDEC_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !ovalid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign live      = acc && !failed_r;
  assign over      = (cnt_r >= {1'b0, max_in_r});
  assign step      = live && !over;
  assign clear     = acc && in_tlast;

  always_comb begin
    res = res_none();
    if (live) begin
      if (over) begin
        res = res_err(ERR_TOO_LONG);
      end else if (hdr_res.valid) begin
        res = hdr_res;
      end else begin
        res = ras_res;
      end
    end

    cnt_nxt    = live ? cnt_r + 1'b1 : cnt_r;
    failed_nxt = failed_r || (res.valid && (res.kind == KIND_ERROR));
    if (clear) begin
      cnt_nxt    = '0;
      failed_nxt = 1'b0;
    end
    ovalid_nxt = in_tready ? res.valid : ovalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      failed_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      failed_r <= failed_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      ores_r <= res;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-4*BYTE_W-2*DIM_W-ERR_W){1'b0}}, ores_r.err,
                       ores_r.alpha, ores_r.blue, ores_r.green, ores_r.red,
                       ores_r.height, ores_r.width};
  assign out_tuser  = ores_r.kind;
  assign out_tlast  = ores_r.last;

endmodule

`default_nettype wire

// ===== hw/rtl/ppm_p6_chk.sv =====
// ----------------------------------------------------------------------------
// ppm_p6_chk
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_p6_chk import ppm_p6_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [KIND_W-1:0]      out_tuser,
  input wire logic                   out_tlast
);

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  a_pixel_alpha : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_PIXEL) |-> out_tdata[63:56] == ALPHA_OPAQUE)
    else $error("pixel without opaque alpha");

  a_last_on_pixel : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_PIXEL)
    else $error("final mark on a non-pixel result");

  a_code_on_error : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_ERROR) |-> out_tdata[67:64] == '0)
    else $error("error code on a non-error result");

endmodule

bind ppm_p6_stream_decoder_top ppm_p6_chk u_chk (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the P6 stream decoder.
// Files are built byte by byte (well-formed headers with random spacing,
// comments and rasters, plus broken and noise files) and streamed in with
// bursty timing. A byte-level model of the parser predicts each header,
// pixel and error item, and every output item is compared field by field.
// The limit registers are swept through reset, tight, widest and zero
// settings between groups of files.
// ----------------------------------------------------------------------------

module tb;
  import ppm_p6_pkg::*;

  localparam int          NO_RESULT  = -1;
  localparam int          GOT_HEADER = 256;
  localparam int          GOT_PIXEL  = 257;
  localparam int          SETTLE     = 8;
  localparam int          HOLD_AT    = 450;
  localparam int          HOLD_LEN   = 300;
  localparam longint      LIMIT      = 300000;

  typedef enum logic [2:0] {
    S_MAGIC, S_WIDTH, S_HEIGHT, S_MAXVAL, S_RASTER, S_DONE
  } parse_state_t;

  typedef enum logic [1:0] {RX_OPEN, RX_DUTY, RX_COIN, RX_SPARSE} rx_pattern_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } file_byte_t;

  typedef struct {
    kind_t      kind;
    bit [15:0]  width;
    bit [15:0]  height;
    bit [7:0]   red;
    bit [7:0]   green;
    bit [7:0]   blue;
    bit [7:0]   alpha;
    err_t       code;
    bit         fin;
  } decoded_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // image_width, image_height, red, green, blue,
                                      // alpha, error_code, zero pad
  logic [KIND_W-1:0]      out_tuser;  // kind
  logic                   out_tlast;  // final_res
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  ppm_p6_stream_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // decoder model state
  parse_state_t p_phase;
  bit           p_in_comment, p_magic_ok, p_ovf, p_bad, p_cr, p_failed;
  int unsigned  p_toklen;
  bit [1:0]     p_chan;
  bit [31:0]    p_accum, p_width, p_height;
  bit [36:0]    p_count;
  bit [33:0]    p_remain;
  bit [7:0]     p_red, p_green;

  bit [35:0]    lim_bytes;
  bit [15:0]    lim_w, lim_h;
  bit [31:0]    lim_pix;
  bit [34:0]    lim_dec;

  file_byte_t   feed_q[$];
  decoded_t     decoded_q[$];
  bit [7:0]     file_buf[$];

  longint       cycle_count    = 0;
  longint       bytes_queued   = 0;
  longint       bytes_accepted = 0;
  int           files_sent     = 0;
  int           mismatches     = 0;
  int           n_headers      = 0;
  int           n_pixels       = 0;
  int           n_errors       = 0;

  int           burst_left = 0;
  int           gap_left   = 0;
  int           calm_bursts = 0;
  int           hold_left  = 0;
  bit           hold_done  = 0;
  int           rx_tick    = 0;
  rx_pattern_t  rx_mode    = RX_OPEN;
  file_byte_t   next_byte;
  decoded_t     got;

  function automatic bit is_blank(bit [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == CH_CR || c == CH_LF || c == 8'h0C || c == 8'h0B;
  endfunction

  function automatic void start_file();
    p_phase = S_MAGIC; p_in_comment = 0; p_toklen = 0; p_magic_ok = 1;
    p_accum = 0; p_ovf = 0; p_bad = 0; p_width = 0; p_height = 0; p_cr = 0;
    p_count = 0; p_remain = 0; p_chan = 0; p_red = 0; p_green = 0; p_failed = 0;
  endfunction

  function automatic void drop_token();
    p_toklen = 0; p_magic_ok = 1; p_accum = 0; p_ovf = 0; p_bad = 0;
  endfunction

  function automatic void take_char(bit [7:0] c);
    int unsigned pos;
    bit [63:0]   v;
    pos = p_toklen;
    if (p_toklen < 7) p_toklen++;
    if (p_phase == S_MAGIC) begin
      if (!((pos == 0 && c == CH_P) || (pos == 1 && c == CH_SIX))) p_magic_ok = 0;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      v = 64'(p_accum) * 64'd10 + 64'(c) - 64'(CH_ZERO);
      if (v > 64'hFFFF_FFFF) p_ovf = 1;
      p_accum = v[31:0];
    end else begin
      p_bad = 1;
    end
  endfunction

  function automatic int judge_token();
    bit ok;
    ok = !p_bad && !p_ovf;
    case (p_phase)
      S_MAGIC: begin
        if (p_magic_ok && p_toklen == 2) return NO_RESULT;
        return ERR_MAGIC;
      end
      S_WIDTH: begin
        if (!ok) return ERR_WIDTH;
        p_width = p_accum;
        return NO_RESULT;
      end
      S_HEIGHT: begin
        if (!ok) return ERR_HEIGHT;
        p_height = p_accum;
        return NO_RESULT;
      end
      default: begin
        if (!ok) return ERR_MAXVAL_SYNTAX;
        if (p_accum == MAXVAL_REQ) return NO_RESULT;
        return ERR_MAXVAL_VALUE;
      end
    endcase
  endfunction

  function automatic int check_dims();
    bit [63:0] pix;
    if (p_width == 0 || p_height == 0 || p_width > 32'(lim_w) || p_height > 32'(lim_h))
      return ERR_DIMS;
    pix = 64'(p_width) * 64'(p_height);
    if (pix > 64'(lim_pix) || pix > 64'(lim_dec) / 64'd4) return ERR_SIZE;
    p_remain = 34'(pix * 64'd3);
    p_phase  = S_RASTER;
    p_chan   = 0;
    return NO_RESULT;
  endfunction

  function automatic int parse_byte(bit [7:0] b, bit eof, output bit fin);
    int code;
    fin = 0;
    if (p_phase <= S_MAXVAL) begin
      if (p_toklen > 0) begin
        if (is_blank(b) || b == CH_HASH) begin
          code = judge_token();
          if (code != NO_RESULT) return code;
          if (p_phase == S_MAXVAL) begin
            if (b == CH_HASH) return ERR_SEPARATOR;
            code = check_dims();
            if (code != NO_RESULT) return code;
            p_cr = (b == CH_CR);
            if (eof) return ERR_RASTER;
            return GOT_HEADER;
          end
          p_phase = parse_state_t'(p_phase + 1);
          drop_token();
          if (b == CH_HASH) p_in_comment = 1;
          if (eof) return ERR_TOKEN_MISSING;
          return NO_RESULT;
        end
        take_char(b);
      end else if (p_in_comment) begin
        if (b == CH_LF || b == CH_CR) p_in_comment = 0;
      end else if (b == CH_HASH) begin
        p_in_comment = 1;
      end else if (!is_blank(b)) begin
        take_char(b);
      end
      if (!eof) return NO_RESULT;
      if (p_toklen == 0) return ERR_TOKEN_MISSING;
      code = judge_token();
      if (code != NO_RESULT) return code;
      if (p_phase == S_MAXVAL) return ERR_SEPARATOR;
      return ERR_TOKEN_MISSING;
    end
    if (p_phase != S_RASTER) return ERR_RASTER;
    if (p_cr) begin
      p_cr = 0;
      if (b == CH_LF) begin
        if (eof) return ERR_RASTER;
        return NO_RESULT;
      end
    end
    if (p_remain > 0) p_remain--;
    if (p_chan == 0) begin
      p_red = b; p_chan = 1;
    end else if (p_chan == 1) begin
      p_green = b; p_chan = 2;
    end else begin
      p_chan = 0;
      if (p_remain == 0) begin
        p_phase = S_DONE;
        fin = eof;
        return GOT_PIXEL;
      end
    end
    if (eof) return ERR_RASTER;
    if (p_chan == 0) return GOT_PIXEL;
    return NO_RESULT;
  endfunction

  function automatic void decode_byte(bit [7:0] b, bit eof);
    int       code;
    bit       fin;
    decoded_t d;
    code = NO_RESULT;
    fin  = 0;
    if (!p_failed) begin
      p_count++;
      if (p_count > 37'(lim_bytes)) code = ERR_TOO_LONG;
      else code = parse_byte(b, eof, fin);
    end
    if (code != NO_RESULT) begin
      d = '{kind: KIND_HEADER, code: ERR_TOO_LONG, default: '0};
      if (code == GOT_HEADER) begin
        d.width  = p_width[15:0];
        d.height = p_height[15:0];
      end else if (code == GOT_PIXEL) begin
        d.kind  = KIND_PIXEL;
        d.red   = p_red;
        d.green = p_green;
        d.blue  = b;
        d.alpha = ALPHA_OPAQUE;
        d.fin   = fin;
      end else begin
        d.kind   = KIND_ERROR;
        d.code   = err_t'(code[3:0]);
        p_failed = 1;
      end
      decoded_q.insert(decoded_q.size(), d);
    end
    if (eof) start_file();
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endtask

  // clock, watchdog

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // sender

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (feed_q.size() > 0) begin
        next_byte = feed_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_byte.data;
        in_tlast  <= next_byte.last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          if (calm_bursts > 0) begin
            calm_bursts--;
            gap_left = 0;
          end else if ($urandom_range(0, 15) == 0) begin
            calm_bursts = $urandom_range(3, 10);
            gap_left = 0;
          end else begin
            gap_left = $urandom_range(1, 6);
          end
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && bytes_accepted >= HOLD_AT) begin
        hold_done = 1;
        hold_left = HOLD_LEN;
        out_tready <= 1'b0;
      end else begin
        if (rx_tick % 97 == 0) rx_mode = rx_pattern_t'($urandom_range(0, 3));
        case (rx_mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_DUTY:   out_tready <= (rx_tick % 5) < 3;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= $urandom_range(0, 3) == 0;
          default:   out_tready <= 1'b1;
        endcase
      end
    end
  end

  // monitor: predict on input items, then check output items

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tlast);
        bytes_accepted++;
      end
      if (out_tvalid && out_tready) begin
        case (out_tuser)
          KIND_HEADER: n_headers++;
          KIND_PIXEL:  n_pixels++;
          default:     n_errors++;
        endcase
        if (decoded_q.size() == 0) begin
          $error("output item with none outstanding: kind %0d", out_tuser);
          mismatches++;
        end else begin
          got = decoded_q.pop_front();
          check_field("kind", got.kind, out_tuser);
          check_field("image_width", got.width, out_tdata[15:0]);
          check_field("image_height", got.height, out_tdata[31:16]);
          check_field("red", got.red, out_tdata[39:32]);
          check_field("green", got.green, out_tdata[47:40]);
          check_field("blue", got.blue, out_tdata[55:48]);
          check_field("alpha", got.alpha, out_tdata[63:56]);
          check_field("error_code", got.code, out_tdata[67:64]);
          check_field("final_res", got.fin, out_tlast);
        end
      end
    end
  end

  // file building

  task automatic add_byte(bit [7:0] b);
    file_buf.insert(file_buf.size(), b);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) file_buf.insert(file_buf.size(), s[i]);
  endtask

  task automatic add_noise(longint n);
    repeat (n) file_buf.insert(file_buf.size(), 8'($urandom_range(0, 255)));
  endtask

  task automatic ship();
    file_byte_t it;
    foreach (file_buf[i]) begin
      it.data = file_buf[i];
      it.last = (i == file_buf.size() - 1);
      feed_q.insert(feed_q.size(), it);
    end
    bytes_queued += file_buf.size();
    files_sent++;
    file_buf.delete();
  endtask

  function automatic bit [7:0] blank_char();
    case ($urandom_range(0, 5))
      0:       return 8'h09;
      1:       return CH_CR;
      2:       return CH_LF;
      3:       return 8'h0C;
      4:       return 8'h0B;
      default: return 8'h20;
    endcase
  endfunction

  task automatic add_comment();
    bit [7:0] c;
    add_byte(CH_HASH);
    repeat ($urandom_range(0, 6)) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_CR || c == CH_LF) c = 8'h7A;
      add_byte(c);
    end
    add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  task automatic add_spacing();
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 5) == 0) add_comment();
      else add_byte(blank_char());
    end
  endtask

  task automatic add_num(longint unsigned v);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) add_byte(CH_ZERO);
    add_text($sformatf("%0d", v));
    if ($urandom_range(0, 39) == 0) add_text("x");
  endtask

  function automatic longint unsigned pick_dim(int maxdim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, maxdim);
    if (r < 87) return 0;
    if (r < 94) return maxdim + $urandom_range(1, 3);
    if (r < 98) return $urandom_range(16380, 70000);
    return 64'd4294967295 + $urandom_range(0, 1);
  endfunction

  task automatic rand_file(int maxdim);
    longint unsigned w, h;
    longint          n;
    int              r;
    if ($urandom_range(0, 99) < 8) begin
      add_noise($urandom_range(1, 12));
      ship();
      return;
    end
    w = pick_dim(maxdim);
    h = pick_dim(maxdim);
    if ($urandom_range(0, 2) == 0) add_spacing();
    if ($urandom_range(0, 24) == 0) begin
      case ($urandom_range(0, 3))
        0:       add_text("P5");
        1:       add_text("P66");
        2:       add_text("p6");
        default: add_text("P");
      endcase
    end else begin
      add_text("P6");
    end
    add_spacing(); add_num(w);
    add_spacing(); add_num(h);
    add_spacing();
    r = $urandom_range(0, 99);
    if (r < 90) add_text("255");
    else if (r < 96) add_num($urandom_range(0, 300));
    else add_text("2x5");
    r = $urandom_range(0, 99);
    if (r < 70) add_byte(blank_char());
    else if (r < 88) begin
      add_byte(CH_CR); add_byte(CH_LF);
    end else if (r < 96) add_byte(CH_CR);
    else add_byte(CH_HASH);
    n = (w * h <= 24) ? 3 * w * h : $urandom_range(0, 40);
    r = $urandom_range(0, 99);
    if (r < 10 && n > 0) n -= $urandom_range(1, n);
    else if (r < 18) n += $urandom_range(1, 4);
    add_noise(n);
    if ($urandom_range(0, 19) == 0 && file_buf.size() > 1) begin
      r = $urandom_range(1, file_buf.size() - 1);
      while (file_buf.size() > r) void'(file_buf.pop_back());
    end
    ship();
  endtask

  task automatic rand_files(longint budget, int maxdim);
    longint stop_at;
    stop_at = bytes_queued + budget;
    while (bytes_queued < stop_at) rand_file(maxdim);
  endtask

  task automatic drain();
    while (feed_q.size() != 0 || in_tvalid || decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(cfg_idx_t idx, bit [35:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      CFG_MAX_INPUT_BYTES:   lim_bytes = v;
      CFG_MAX_WIDTH:         lim_w     = v[15:0];
      CFG_MAX_HEIGHT:        lim_h     = v[15:0];
      CFG_MAX_PIXELS:        lim_pix   = v[31:0];
      CFG_MAX_DECODED_BYTES: lim_dec   = v[34:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // main sequence

  initial begin
    lim_bytes = RST_MAX_INPUT_BYTES;
    lim_w     = RST_MAX_WIDTH;
    lim_h     = RST_MAX_HEIGHT;
    lim_pix   = RST_MAX_PIXELS;
    lim_dec   = RST_MAX_DECODED_BYTES;
    start_file();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    add_text("P6 1 1 255\n"); add_byte(8'h00); add_byte(8'hFF); add_byte(8'h80); ship();
    add_text("P6\t2\n1"); add_byte(8'h0B); add_text("255"); add_byte(CH_CR); add_byte(CH_LF);
    add_byte(8'h55); add_byte(8'hAA); add_byte(8'h0F); add_byte(8'hF0); add_byte(8'h33);
    add_byte(8'hCC); ship();
    add_text("#c"); add_byte(CH_CR); add_text("P6#x\n1 1"); add_byte(8'h0C);
    add_text("0255 "); add_noise(3); ship();
    add_text("P7 1"); ship();
    add_text("P66 "); ship();
    add_text("P6 1x 1"); ship();
    add_text("P6 1 4294967296 "); ship();
    add_text("P6 4294967295 1 255\n"); ship();
    add_text("P6 1 1 25a\n"); ship();
    add_text("P6 1 1 254\n"); ship();
    add_text("P6 1 1 255#"); ship();
    add_text("P6 1"); ship();
    add_text("\n"); ship();
    add_text("P6 1 1 255"); ship();
    add_text("P6 0 1 255\n"); ship();
    add_text("P6 16385 1 255\n"); ship();
    add_text("P6 16384 16384 255\n"); ship();
    add_text("P6 1 1 255\n"); ship();
    add_text("P6 2 1 255\n"); add_noise(4); ship();
    add_text("P6 1 1 255\n"); add_noise(5); ship();
    add_text("P6 1 1 255"); add_byte(CH_CR); add_byte(8'h41); add_byte(8'h42);
    add_byte(8'h43); ship();
    add_text("P6 1 1 255"); add_byte(CH_CR); add_byte(CH_LF); ship();
    rand_files(250, 4);
    drain();

    // tight limits
    write_limit(CFG_MAX_INPUT_BYTES, 36'd40);
    write_limit(CFG_MAX_WIDTH, 36'd4);
    write_limit(CFG_MAX_HEIGHT, 36'd3);
    write_limit(CFG_MAX_PIXELS, 36'd6);
    write_limit(CFG_MAX_DECODED_BYTES, 36'd20);
    rand_files(150, 4);
    drain();

    // widest limits
    write_limit(CFG_MAX_INPUT_BYTES, 36'hF_FFFF_FFFF);
    write_limit(CFG_MAX_WIDTH, 36'd65535);
    write_limit(CFG_MAX_HEIGHT, 36'd65535);
    write_limit(CFG_MAX_PIXELS, 36'hFFFF_FFFF);
    write_limit(CFG_MAX_DECODED_BYTES, 36'h4_0000_0000);
    add_text("P6 65535 65535 255\n"); add_noise(4); ship();
    rand_files(80, 5);
    drain();

    // zero limits: every file stops at once
    write_limit(CFG_MAX_INPUT_BYTES, 36'd0);
    write_limit(CFG_MAX_WIDTH, 36'd1);
    write_limit(CFG_MAX_HEIGHT, 36'd1);
    write_limit(CFG_MAX_PIXELS, 36'd0);
    write_limit(CFG_MAX_DECODED_BYTES, 36'd0);
    repeat (5) rand_file(2);
    drain();
    write_limit(CFG_MAX_INPUT_BYTES, 36'hF_FFFF_FFFF);
    repeat (10) rand_file(2);
    drain();

    $display("Streamed %0d files, %0d bytes; checked %0d headers, %0d pixels, %0d errors",
             files_sent, bytes_accepted, n_headers, n_pixels, n_errors);
    $display("Limit settings covered: reset values, tight, widest and zero");
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
